[sv/kefq_pkg.sv]
// Shared constants, codes and types of the key event filter queue.
`timescale 1ns / 1ps

package kefq_pkg;

	localparam int KEY_COUNT   = 256;
	localparam int QUEUE_DEPTH = 256;

	localparam int FUNC_W    = 3;
	localparam int KEY_W     = 8;
	localparam int COUNT_W   = 9;
	localparam int KEY_IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int WALK_W    = $clog2(KEY_COUNT + 1);
	localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 24;

	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(256);

	localparam logic [FUNC_W-1:0] FN_ADD    = 3'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_PRESS  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_REL    = 3'd3;
	localparam logic [FUNC_W-1:0] FN_POP    = 3'd4;
	localparam logic [FUNC_W-1:0] FN_RELALL = 3'd5;
	localparam logic [FUNC_W-1:0] FN_REMALL = 3'd6;

	typedef struct packed {
		logic enabled;
		logic pressed;
	} map_entry_t;

	typedef struct packed {
		logic [COUNT_W-1:0] active;
		logic               pressed;
		logic [KEY_W-1:0]   key;
	} event_t;

endpackage

[sv/key_event_filter_queue_core.sv]
// Key event filter queue: top level with the operation sequencer and result register.
`timescale 1ns / 1ps

// Keeps an enable and a pressed bit per key in a registered-read key memory and
// queues press/release events in an event memory FIFO. Add, remove, press, release
// and pop first read the key memory (or the event memory for pop), then modify,
// write back and load the result register. Release-all and remove-all walk every
// key through the key memory, one key per cycle. The key memory's valid bits clear
// at reset, so the block is ready right after reset with no clearing pass. A
// finished result waits in the output register while the next item is taken; an
// item holds in its final step only while the previous result is still untaken.
module key_event_filter_queue_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// func [2:0], key [10:3], zero fill
	input  logic [kefq_pkg::S_DATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// ok [0], event_key [8:1], event_pressed [9], event_active [18:10], zero fill
	output logic [kefq_pkg::M_DATA_W-1:0] m_tdata
);
	import kefq_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q, state_d;
	logic [FUNC_W-1:0] func_q;
	logic [KEY_W-1:0]  key_q;
	logic              key_ok_q;
	logic [COUNT_W-1:0] active_q, active_d;
	logic [WALK_W-1:0]  walk_rd_q;
	logic               walk_v_s1;
	logic [KEY_IDX_W-1:0] walk_addr_s1;

	logic m_tvalid_q;
	logic res_ok_q;
	event_t res_ev_q;

	logic [FUNC_W-1:0] s_func;
	logic [KEY_W-1:0]  s_key;
	logic s_key_ok, s_walk, s_accept, out_free;

	logic map_rd_en, map_wr_en;
	logic [KEY_IDX_W-1:0] map_rd_addr, map_wr_addr;
	map_entry_t map_rd_data, map_wr_data;

	logic ev_push, ev_pop, ev_rd_req, ev_full, ev_empty;
	event_t ev_push_data, ev_rd_data;

	logic ld_out, ld_ok;
	event_t ld_ev;
	logic [COUNT_W-1:0] cnt_inc, cnt_dec;

	assign s_func   = s_tdata[2:0];
	assign s_key    = s_tdata[10:3];
	assign s_key_ok = ((KEY_W + 1)'(s_key) < (KEY_W + 1)'(KEY_COUNT));
	assign s_walk   = s_func inside {FN_RELALL, FN_REMALL};
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign cnt_inc = (active_q >= COUNT_MAX) ? COUNT_MAX : active_q + 1'b1;
	assign cnt_dec = (active_q == '0) ? '0 : active_q - 1'b1;

	kefq_keymap u_keymap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (map_rd_en),
		.rd_addr (map_rd_addr),
		.rd_data (map_rd_data),
		.wr_en   (map_wr_en),
		.wr_addr (map_wr_addr),
		.wr_data (map_wr_data)
	);

	kefq_evq u_evq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ev_push),
		.push_data (ev_push_data),
		.rd_req    (ev_rd_req),
		.pop       (ev_pop),
		.rd_data   (ev_rd_data),
		.full      (ev_full),
		.empty     (ev_empty)
	);

	always_comb begin
		state_d      = state_q;
		active_d     = active_q;
		map_rd_en    = 1'b0;
		map_rd_addr  = s_key[KEY_IDX_W-1:0];
		map_wr_en    = 1'b0;
		map_wr_addr  = key_q[KEY_IDX_W-1:0];
		map_wr_data  = map_rd_data;
		ev_push      = 1'b0;
		ev_push_data = '{active: cnt_dec, pressed: 1'b0, key: key_q};
		ev_pop       = 1'b0;
		ev_rd_req    = 1'b0;
		ld_out       = 1'b0;
		ld_ok        = 1'b0;
		ld_ev        = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					if (s_walk) begin
						state_d = ST_WALK;
					end else begin
						state_d   = ST_EXEC;
						map_rd_en = s_key_ok;
						ev_rd_req = (s_func == FN_POP);
					end
				end
			end
			ST_EXEC: begin
				// read data holds while the result register is still occupied
				if (out_free) begin
					ld_out  = 1'b1;
					state_d = ST_IDLE;
					unique case (func_q)
						FN_ADD: begin
							if (key_ok_q && !map_rd_data.enabled) begin
								map_wr_en           = 1'b1;
								map_wr_data.enabled = 1'b1;
								ld_ok               = 1'b1;
							end
						end
						FN_REMOVE: begin
							if (key_ok_q) begin
								map_wr_en           = 1'b1;
								map_wr_data.enabled = 1'b0;
								ld_ok               = map_rd_data.enabled;
								// release first; a full queue leaves the key pressed
								if (map_rd_data.pressed && !ev_full) begin
									ev_push             = 1'b1;
									active_d            = cnt_dec;
									map_wr_data.pressed = 1'b0;
								end
							end
						end
						FN_PRESS: begin
							if (key_ok_q && map_rd_data.enabled && !map_rd_data.pressed
									&& !ev_full) begin
								ev_push              = 1'b1;
								ev_push_data.pressed = 1'b1;
								ev_push_data.active  = cnt_inc;
								active_d             = cnt_inc;
								map_wr_en            = 1'b1;
								map_wr_data.pressed  = 1'b1;
								ld_ok                = 1'b1;
							end
						end
						FN_REL: begin
							if (key_ok_q && map_rd_data.pressed && !ev_full) begin
								ev_push             = 1'b1;
								active_d            = cnt_dec;
								map_wr_en           = 1'b1;
								map_wr_data.pressed = 1'b0;
								ld_ok               = 1'b1;
							end
						end
						FN_POP: begin
							if (!ev_empty) begin
								ev_pop = 1'b1;
								ld_ok  = 1'b1;
								ld_ev  = ev_rd_data;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				// read key n+1 while key n is written back
				map_rd_en   = (walk_rd_q < WALK_W'(KEY_COUNT));
				map_rd_addr = walk_rd_q[KEY_IDX_W-1:0];
				map_wr_addr = walk_addr_s1;
				ev_push_data.key = KEY_W'(walk_addr_s1);
				if (walk_v_s1) begin
					map_wr_en = 1'b1;
					if (func_q == FN_REMALL) begin
						map_wr_data.enabled = 1'b0;
					end
					if (map_rd_data.pressed && !ev_full) begin
						ev_push             = 1'b1;
						active_d            = cnt_dec;
						map_wr_data.pressed = 1'b0;
					end
					if (walk_addr_s1 == KEY_IDX_W'(KEY_COUNT - 1)) begin
						active_d = '0;
						state_d  = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				if (out_free) begin
					ld_out  = 1'b1;
					ld_ok   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			active_q   <= '0;
			walk_rd_q  <= '0;
			walk_v_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			active_q <= active_d;
			if (s_accept) begin
				walk_rd_q <= '0;
				walk_v_s1 <= 1'b0;
			end else if (state_q == ST_WALK) begin
				walk_v_s1 <= map_rd_en;
				if (map_rd_en) begin
					walk_rd_q <= walk_rd_q + 1'b1;
				end
			end
			if (ld_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			func_q   <= s_func;
			key_q    <= s_key;
			key_ok_q <= s_key_ok;
		end
		if (state_q == ST_WALK) begin
			walk_addr_s1 <= walk_rd_q[KEY_IDX_W-1:0];
		end
		if (ld_out) begin
			res_ok_q <= ld_ok;
			res_ev_q <= ld_ev;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, res_ev_q, res_ok_q};

	a_map_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(map_rd_en && map_wr_en) |-> (map_rd_addr != map_wr_addr))
		else $error("key memory read and write hit the same entry");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> (state_q != ST_IDLE))
		else $error("sequencer idle right after a transfer was taken");
	a_walk_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (active_q == '0))
		else $error("pressed count not zero after key walk");

endmodule

[sv/kefq_keymap.sv]
// Per-key enable/pressed memory with reset-cleared valid bits.
`timescale 1ns / 1ps

module kefq_keymap (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             rd_en,
	input  logic [kefq_pkg::KEY_IDX_W-1:0]   rd_addr,
	output kefq_pkg::map_entry_t             rd_data,
	input  logic                             wr_en,
	input  logic [kefq_pkg::KEY_IDX_W-1:0]   wr_addr,
	input  kefq_pkg::map_entry_t             wr_data
);
	import kefq_pkg::*;

	map_entry_t mem_q [KEY_COUNT];
	logic [KEY_COUNT-1:0] valid_q;
	map_entry_t raw_q;
	logic       raw_v_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			raw_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			raw_v_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				raw_v_q <= valid_q[rd_addr];
			end
		end
	end

	// an entry never written reads as cleared
	assign rd_data = raw_v_q ? raw_q : '0;

endmodule

[sv/kefq_evq.sv]
// Event FIFO: event memory, read/write pointers and fill count.
`timescale 1ns / 1ps

module kefq_evq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  kefq_pkg::event_t  push_data,
	input  logic              rd_req,
	input  logic              pop,
	output kefq_pkg::event_t  rd_data,
	output logic              full,
	output logic              empty
);
	import kefq_pkg::*;

	event_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
		if (rd_req) begin
			rd_data <= mem_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("event pushed into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("event popped from empty queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue fill count out of range");

endmodule

[sim/key_event_filter_queue_core_tb.sv]
// Self-checking testbench for the key event filter queue core: ops in, events out.
`timescale 1ns / 1ps

module key_event_filter_queue_core_tb;
	import kefq_pkg::*;

	localparam logic [FUNC_W-1:0] FN_UNDEF = 3'd7;
	localparam int RANDOM_ITEMS = 450;
	localparam int QUIET_LIMIT  = 4000;

	// one result transfer as it sits in m_tdata, lowest field last
	typedef struct packed {
		logic [COUNT_W-1:0] active;
		logic               pressed;
		logic [KEY_W-1:0]   key;
		logic               ok;
	} key_result_t;

	class key_tracker;
		bit          enabled[KEY_COUNT];
		bit          pressed[KEY_COUNT];
		int unsigned active;
		event_t      queued[$];
		key_result_t due[$];
		int          errors;
		int          checked;
		int          refusals;
		int          popped;

		function void fault(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			if (errors <= 10)
				$display("MISMATCH %s: expected %0h got %0h at %0t", what, want, got, $realtime);
		endfunction

		function bit queue_event(logic [KEY_W-1:0] k, bit dir, int unsigned cnt);
			event_t ev;
			if (queued.size() >= QUEUE_DEPTH) begin
				refusals++;
				return 0;
			end
			ev.key     = k;
			ev.pressed = dir;
			ev.active  = COUNT_W'(cnt);
			queued.push_back(ev);
			return 1;
		endfunction

		function bit press_key(logic [KEY_W-1:0] k);
			int unsigned nxt;
			if (!enabled[k] || pressed[k])
				return 0;
			nxt = (active >= 256) ? 256 : active + 1;
			if (!queue_event(k, 1'b1, nxt))
				return 0;
			pressed[k] = 1;
			active = nxt;
			return 1;
		endfunction

		function bit release_key(logic [KEY_W-1:0] k);
			int unsigned nxt;
			if (!pressed[k])
				return 0;
			// count saturates at zero after a forced clear
			nxt = (active == 0) ? 0 : active - 1;
			if (!queue_event(k, 1'b0, nxt))
				return 0;
			pressed[k] = 0;
			active = nxt;
			return 1;
		endfunction

		function bit remove_key(logic [KEY_W-1:0] k);
			void'(release_key(k));
			if (!enabled[k])
				return 0;
			enabled[k] = 0;
			return 1;
		endfunction

		function void apply_op(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] k);
			key_result_t r;
			event_t      ev;
			bit          key_ok;
			r = '0;
			key_ok = int'(k) < KEY_COUNT;
			case (fn)
				FN_ADD: begin
					if (key_ok && !enabled[k]) begin
						enabled[k] = 1;
						r.ok = 1'b1;
					end
				end
				FN_REMOVE: if (key_ok) r.ok = remove_key(k);
				FN_PRESS:  if (key_ok) r.ok = press_key(k);
				FN_REL:    if (key_ok) r.ok = release_key(k);
				FN_POP: begin
					if (queued.size() > 0) begin
						ev = queued.pop_front();
						r.ok      = 1'b1;
						r.key     = ev.key;
						r.pressed = ev.pressed;
						r.active  = ev.active;
						popped++;
					end
				end
				FN_RELALL: begin
					for (int i = 0; i < KEY_COUNT; i++)
						void'(release_key(KEY_W'(i)));
					active = 0;
					r.ok = 1'b1;
				end
				FN_REMALL: begin
					for (int i = 0; i < KEY_COUNT; i++)
						void'(remove_key(KEY_W'(i)));
					active = 0;
					r.ok = 1'b1;
				end
				default: ;
			endcase
			due.push_back(r);
		endfunction

		function void compare_result(logic [M_DATA_W-1:0] data);
			key_result_t got;
			key_result_t want;
			got = data[$bits(key_result_t)-1:0];
			if (due.size() == 0) begin
				fault("result with nothing pending", 32'd0, 32'(got));
				return;
			end
			want = due.pop_front();
			checked++;
			if (got.ok !== want.ok)
				fault("ok", 32'(want.ok), 32'(got.ok));
			if (got.key !== want.key)
				fault("event_key", 32'(want.key), 32'(got.key));
			if (got.pressed !== want.pressed)
				fault("event_pressed", 32'(want.pressed), 32'(got.pressed));
			if (got.active !== want.active)
				fault("event_active", 32'(want.active), 32'(got.active));
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;

	key_tracker   tracker = new;
	int           n_sent;
	int           n_bulk;
	int           idle_mode;
	int           quiet;
	logic [KEY_W-1:0] hot_keys[8];

	key_event_filter_queue_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// idle modes: 0 none, 1 sender gaps, 2 receiver stalls, 3 both
	task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] k);
		int gap_pct;
		gap_pct = (idle_mode == 1) ? 56 : (idle_mode == 3) ? 22 : 0;
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_DATA_W'({k, fn});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.apply_op(fn, k);
		n_sent++;
		if (fn == FN_RELALL || fn == FN_REMALL)
			n_bulk++;
		idle_mode = (n_sent / 40) % 4;
	endtask

	task automatic pop_events(input int count);
		repeat (count)
			send_op(FN_POP, KEY_W'($urandom));
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 99) < 80)
			return hot_keys[$urandom_range(0, 7)];
		return KEY_W'($urandom);
	endfunction

	// result side: check each transfer, then pick next cycle's ready
	initial begin
		int stall_pct;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				tracker.compare_result(m_tdata);
			stall_pct = (idle_mode == 2) ? 56 : (idle_mode == 3) ? 22 : 0;
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		logic [KEY_W-1:0] ka;
		logic [KEY_W-1:0] kb;
		bit               flooded;
		int               sel;
		int               directed;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		n_sent    = 0;
		n_bulk    = 0;
		idle_mode = 0;
		flooded   = 0;
		hot_keys[0] = '0;
		hot_keys[1] = '1;
		for (int i = 2; i < 8; i++)
			hot_keys[i] = KEY_W'($urandom);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every op, empty pop, undefined func, remove while pressed
		send_op(FN_POP, 8'h00);
		send_op(FN_ADD, 8'h00);
		send_op(FN_ADD, 8'hFF);
		send_op(FN_ADD, 8'h00);
		send_op(FN_PRESS, 8'h00);
		send_op(FN_PRESS, 8'hFF);
		send_op(FN_PRESS, 8'h00);
		send_op(FN_PRESS, 8'h11);
		send_op(FN_REL, 8'h00);
		send_op(FN_REL, 8'h00);
		send_op(FN_POP, 8'hFF);
		send_op(FN_UNDEF, 8'hAA);
		send_op(FN_REMOVE, 8'hFF);
		send_op(FN_REMOVE, 8'hFF);
		send_op(FN_ADD, 8'h80);
		send_op(FN_PRESS, 8'h80);
		send_op(FN_RELALL, 8'h55);
		pop_events(3);
		send_op(FN_ADD, 8'h7F);
		send_op(FN_REMALL, 8'h00);
		send_op(FN_REL, 8'h80);
		pop_events(2);
		directed = n_sent;

		while (n_sent < directed + RANDOM_ITEMS) begin
			if (!flooded && n_sent > directed + 120) begin
				// fill the queue, then make releases fail while it is full
				flooded = 1;
				ka = KEY_W'($urandom);
				kb = ka ^ 8'h80;
				pop_events(tracker.queued.size());
				send_op(FN_ADD, ka);
				send_op(FN_ADD, kb);
				send_op(FN_REL, ka);
				send_op(FN_REL, kb);
				send_op(FN_PRESS, kb);
				while (tracker.queued.size() < QUEUE_DEPTH) begin
					send_op(FN_PRESS, ka);
					send_op(FN_REL, ka);
				end
				send_op(FN_PRESS, ka);
				send_op(FN_RELALL, ka);
				send_op(FN_REMOVE, kb);
				pop_events(6);
				// kb is still pressed with the count already forced to zero
				send_op(FN_REL, kb);
				send_op(FN_REL, kb);
				pop_events($urandom_range(1, 8));
			end else begin
				sel = $urandom_range(0, 99);
				if (sel < 50) begin
					ka = pick_key();
					send_op(FN_ADD, ka);
					send_op(FN_PRESS, ka);
					if ($urandom_range(0, 1))
						send_op(FN_PRESS, pick_key());
					send_op(FN_REL, ka);
					if ($urandom_range(0, 3) == 0)
						send_op(FN_REMOVE, ka);
					pop_events($urandom_range(1, 3));
				end else if (sel < 65) begin
					send_op(FUNC_W'($urandom_range(0, 7)),
						$urandom_range(0, 1) ? KEY_W'($urandom) : pick_key());
				end else if (sel < 75) begin
					pop_events($urandom_range(1, 6));
				end else if (sel < 80) begin
					send_op($urandom_range(0, 1) ? FN_RELALL : FN_REMALL, KEY_W'($urandom));
				end else begin
					repeat ($urandom_range(2, 6))
						send_op($urandom_range(0, 1) ? FN_PRESS : FN_REL, pick_key());
				end
			end
		end
		s_tvalid <= 1'b0;

		while (tracker.due.size() != 0)
			@(posedge clk);
		repeat (KEY_COUNT + 20) @(posedge clk);
		if (tracker.due.size() != 0)
			tracker.fault("results still pending", 32'(tracker.due.size()), 32'd0);

		$display("Ran %0d ops (%0d directed, %0d bulk walks), %0d results checked",
			n_sent, directed, n_bulk, tracker.checked);
		$display("Popped %0d events, %0d event writes refused on a full queue, %0d errors",
			tracker.popped, tracker.refusals, tracker.errors);
		if (tracker.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
